// ===== hdl/gbsf_pkg.sv =====
// Shared types and constants for the gyro bias stillness filter.
// Used by every module under hdl; depends on nothing.
package gbsf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BIAS_W     = 40;
    localparam int THR_W      = 15;
    localparam int STILL_W    = 16;
    localparam int ALPHA_W    = 25;
    localparam int ALPHA_BITS = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int LANES      = 3;
    localparam int SPLIT_W    = 20;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 25'h100_0000;
    localparam logic [THR_W-1:0]   THR_RESET       = 15'd30;
    localparam logic [STILL_W-1:0] STILL_RESET     = 16'd2000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 25'd16775108;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_STILL     = 2'd1,
        CFG_ALPHA     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic fire;
        logic track;
    } lane_ctrl_t;

endpackage

// ===== hdl/gbsf_lane.sv =====
// One axis lane: threshold test, split alpha*bias multiply and bias register.
// Depends on gbsf_pkg.
module gbsf_lane #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gbsf_pkg::lane_ctrl_t                ctrl,
    input  logic [gbsf_pkg::THR_W-1:0]          threshold,
    input  logic [gbsf_pkg::ALPHA_W-1:0]        alpha,
    input  logic [gbsf_pkg::ALPHA_W-1:0]        beta,
    input  logic signed [gbsf_pkg::SAMPLE_W-1:0] rate,
    output logic                                over,
    output logic signed [gbsf_pkg::BIAS_W-1:0]  offset
);
    import gbsf_pkg::*;

    localparam int LO_W  = SPLIT_W;
    localparam int HI_W  = BIAS_W - SPLIT_W;
    localparam int PL_W  = ALPHA_W + 1 + LO_W + 1;
    localparam int PH_W  = ALPHA_W + 1 + HI_W;
    localparam int Q_W   = ALPHA_W + 1 + SAMPLE_W;
    localparam int P_W   = ALPHA_W + 1 + BIAS_W;
    localparam int SUM_W = ((P_W > Q_W + FRAC_BITS) ? P_W : Q_W + FRAC_BITS) + 2;

    logic signed [SAMPLE_W:0]   rate_ext;
    logic signed [SAMPLE_W:0]   thr_ext;
    logic signed [ALPHA_W:0]    alpha_s;
    logic signed [ALPHA_W:0]    beta_s;
    logic signed [PL_W-1:0]     pp_lo_reg, pp_lo_next;
    logic signed [PH_W-1:0]     pp_hi_reg, pp_hi_next;
    logic signed [Q_W-1:0]      q_reg, q_next;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    shifted;
    logic [SUM_W-BIAS_W:0]      top_bits;
    logic                       pos_ovf, neg_ovf;
    logic signed [BIAS_W-1:0]   res;
    logic signed [BIAS_W-1:0]   bias_reg, bias_next;
    logic signed [BIAS_W-1:0]   offset_reg;

    assign rate_ext = (SAMPLE_W + 1)'(rate);
    assign thr_ext  = $signed((SAMPLE_W + 1)'(threshold));
    assign over     = (rate_ext > thr_ext) || (rate_ext < -thr_ext);

    assign alpha_s = $signed({1'b0, alpha});
    assign beta_s  = $signed({1'b0, beta});

    // alpha*bias split into a low unsigned and a high signed half
    assign pp_lo_next = alpha_s * $signed({1'b0, bias_reg[LO_W-1:0]});
    assign pp_hi_next = alpha_s * $signed(bias_reg[BIAS_W-1:LO_W]);
    assign q_next     = beta_s * rate;

    assign sum = (SUM_W'(pp_hi_reg) <<< LO_W) + SUM_W'(pp_lo_reg)
               + (SUM_W'(q_reg) <<< FRAC_BITS);
    assign shifted  = sum >>> ALPHA_BITS;
    assign top_bits = shifted[SUM_W-1:BIAS_W-1];
    assign pos_ovf  = !shifted[SUM_W-1] && (|top_bits);
    assign neg_ovf  = shifted[SUM_W-1] && !(&top_bits);

    always_comb begin
        if (pos_ovf) begin
            res = {1'b0, {(BIAS_W - 1){1'b1}}};
        end else if (neg_ovf) begin
            res = {1'b1, {(BIAS_W - 1){1'b0}}};
        end else begin
            res = shifted[BIAS_W-1:0];
        end
    end

    assign bias_next = (ctrl.fire && ctrl.track) ? res : bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= '0;
        end else begin
            bias_reg <= bias_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            q_reg     <= q_next;
        end
        if (ctrl.fire) begin
            offset_reg <= bias_next;
        end
    end

    assign offset = offset_reg;

endmodule

// ===== hdl/gbsf_ctrl.sv =====
// Merge and control: configuration registers, quiet counter, stage handshakes.
// Combines the lanes' threshold flags; depends on gbsf_pkg.
module gbsf_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [gbsf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gbsf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [gbsf_pkg::LANES-1:0]         over,
    output gbsf_pkg::lane_ctrl_t               ctrl,
    output logic [gbsf_pkg::THR_W-1:0]         threshold,
    output logic [gbsf_pkg::ALPHA_W-1:0]       alpha,
    output logic [gbsf_pkg::ALPHA_W-1:0]       beta,
    output logic                               moving,
    output logic                               tracking
);
    import gbsf_pkg::*;

    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [STILL_W-1:0] still_reg, still_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [STILL_W-1:0] quiet_reg, quiet_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_move_reg, s1_track_reg;
    logic               m_valid_reg, m_valid_next;
    logic               m_move_reg, m_track_reg;
    logic               adv, accept, move_now, track_now;

    always_comb begin
        thr_next   = thr_reg;
        still_next = still_reg;
        alpha_next = alpha_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD: thr_next   = cfg_wdata[THR_W-1:0];
                CFG_STILL:     still_next = cfg_wdata[STILL_W-1:0];
                CFG_ALPHA:     alpha_next = cfg_wdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    assign threshold = thr_reg;
    assign alpha     = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign beta      = ALPHA_ONE - alpha;

    // a tracking item in stage 1 holds off new input until it leaves, closing the bias loop
    assign adv       = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || (adv && !s1_track_reg);
    assign accept    = s_tvalid && s_tready;
    assign move_now  = |over;
    assign track_now = !move_now && (quiet_reg >= still_reg);

    always_comb begin
        quiet_next = quiet_reg;
        if (accept) begin
            if (move_now) begin
                quiet_next = '0;
            end else if (!track_now) begin
                quiet_next = quiet_reg + 1'b1;
            end
        end
    end

    assign s1_valid_next = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = adv ? s1_valid_reg : m_valid_reg;

    assign ctrl.load  = accept;
    assign ctrl.fire  = s1_valid_reg && adv;
    assign ctrl.track = s1_track_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= THR_RESET;
            still_reg    <= STILL_RESET;
            alpha_reg    <= ALPHA_RESET;
            quiet_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_track_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            thr_reg      <= thr_next;
            still_reg    <= still_next;
            alpha_reg    <= alpha_next;
            quiet_reg    <= quiet_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (accept) begin
                s1_track_reg <= track_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_move_reg <= move_now;
        end
        if (ctrl.fire) begin
            m_move_reg  <= s1_move_reg;
            m_track_reg <= s1_track_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign moving   = m_move_reg;
    assign tracking = m_track_reg;

endmodule

// ===== hdl/gyro_bias_stillness_filter_top.sv =====
// An accepted item passes through stage 1 and the output register to m_tvalid.
// Throughput: 1 item per cycle while m_tready is high; an item that updates the biases
// blocks the next item until it leaves stage 1, so each lane's bias feedback loop closes.
// Reset (aresetn low, synchronous): clears quiet counter, biases and valid flags,
// and returns the configuration registers to their default values.
// Instantiates gbsf_ctrl and three gbsf_lane; depends on gbsf_pkg.
module gyro_bias_stillness_filter_top #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [gbsf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gbsf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [3*gbsf_pkg::SAMPLE_W-1:0]       s_tdata,  // rate_x, rate_y, rate_z
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [3*gbsf_pkg::BIAS_W-1:0]         m_tdata,  // offset_x, offset_y, offset_z
    output logic [1:0]                            m_tuser   // moving, tracking
);
    import gbsf_pkg::*;

    lane_ctrl_t           ctrl;
    logic [THR_W-1:0]     threshold;
    logic [ALPHA_W-1:0]   alpha;
    logic [ALPHA_W-1:0]   beta;
    logic [LANES-1:0]     over;
    logic                 moving, tracking;

    gbsf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .over      (over),
        .ctrl      (ctrl),
        .threshold (threshold),
        .alpha     (alpha),
        .beta      (beta),
        .moving    (moving),
        .tracking  (tracking)
    );

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        gbsf_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .threshold (threshold),
            .alpha     (alpha),
            .beta      (beta),
            .rate      ($signed(s_tdata[i*SAMPLE_W +: SAMPLE_W])),
            .over      (over[i]),
            .offset    (m_tdata[i*BIAS_W +: BIAS_W])
        );
    end

    assign m_tuser = {tracking, moving};

endmodule

// ===== hdl/gbsf_checker.sv =====
// Port-level checks on the gyro bias stillness filter, bound to its top level.
// Depends on gyro_bias_stillness_filter_top and gbsf_pkg.
module gbsf_props (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [3*gbsf_pkg::BIAS_W-1:0]         m_tdata,
    input logic [1:0]                            m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("item flagged both moving and tracking");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty straight after reset");

endmodule

bind gyro_bias_stillness_filter_top gbsf_props u_gbsf_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
